// ----- hdl/puabmac_pkg.sv -----
// shared types and constants of the packed upper-triangle a-transpose-b mac block
// no dependencies; imported by every module of the block but the ram
`default_nettype none

package puabmac_pkg;

    // default sizes of the block
    localparam int DEF_MAX_INNER  = 16;
    localparam int DEF_MAX_COLS   = 8;
    localparam int DEF_DATA_WIDTH = 32;

    // fixed field widths of the streams and the configuration port
    localparam int OP_W      = 2;
    localparam int ROW_W     = 4;
    localparam int COL_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int INNER_W   = 5;
    localparam int COLS_W    = 4;
    localparam int GAIN_W    = 32;

    // shared multiplier operands: the 32-bit gains plus one bit for unsigned chunks
    localparam int MUL_W  = GAIN_W + 1;
    // step index of the scale phase: at most three dot chunks and the beta term
    localparam int STEP_W = 2;

    // input opcodes carried in tuser
    localparam logic [OP_W-1:0] OP_LOAD_A = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD_B = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD_C = 2'd2;
    localparam logic [OP_W-1:0] OP_START  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INNER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA  = 2'd3;

    // operand source of the shared multiplier
    typedef enum logic [1:0] {
        SRC_AB   = 2'd0,
        SRC_LOW  = 2'd1,
        SRC_TOP  = 2'd2,
        SRC_BETA = 2'd3
    } t_src;

    // sequencer to datapath control
    typedef struct packed {
        logic              mul_vld;
        t_src              src;
        logic [STEP_W-1:0] step;
        logic              clr;
        logic              cap;
        logic              emit;
        logic              last;
    } t_mac_ctl;

endpackage

`default_nettype wire

// ----- hdl/packed_upper_at_b_multiply_accumulate_unit.sv -----
// top level of the packed upper-triangle c = alpha * a'b + beta * c mac block
// depends on puabmac_pkg, puabmac_ram, puabmac_mul_acc and puabmac_seq
//
// usage:
//   s_axis carries one item per transaction; tuser is the opcode (load a, load b,
//   load old c, start). loads write one element into the a, b or packed c memory
//   and are taken at one per cycle while the block is idle; out-of-range loads
//   are dropped. a start transaction runs the whole upper triangle of c, column by
//   column, row 0 up to the column, and s_axis_tready stays low until the last
//   entry has been handed to the output register.
//   m_axis carries one c entry per transaction, tlast on the final entry and the
//   overflow flag in tuser.
//   each entry uses the one shared 33x33 multiplier for k dot product steps (one
//   memory read of a and b per step), then three chunk products of alpha times the
//   wide dot sum and one beta times old c product, with the two-stage
//   multiply/accumulate pipe drained after each phase.
//   the output register frees the datapath: a result waits there while the next
//   entry is being computed; if the receiver holds tready low the sequencer
//   waits before writing the next result. the configuration port must be written
//   only while idle; the block does not enforce this. reset restores k = 16,
//   n = 8, alpha = 1, beta = 0 and empties the output. memories are not cleared:
//   an element must be loaded before a start reads it.
`default_nettype none

module packed_upper_at_b_multiply_accumulate_unit #(
    parameter int MAX_INNER  = puabmac_pkg::DEF_MAX_INNER,
    parameter int MAX_COLS   = puabmac_pkg::DEF_MAX_COLS,
    parameter int DATA_WIDTH = puabmac_pkg::DEF_DATA_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration write port
    input  wire logic                                i_cfg_we,
    input  wire logic [puabmac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [puabmac_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // input stream
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [3:0] row, [6:4] col, [38:7] value, [39] zero
    input  wire logic [puabmac_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // [1:0] op
    input  wire logic [puabmac_pkg::OP_W-1:0]        s_axis_tuser,
    // result stream
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [2:0] out_row, [5:3] out_col, [37:6] out_value, [39:38] zero
    output logic [puabmac_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    // [0] overflow
    output logic                                     m_axis_tuser,
    output logic                                     m_axis_tlast
);

    import puabmac_pkg::*;

    localparam int RW      = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1;
    localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ABD     = MAX_INNER * MAX_COLS;
    localparam int ABAW    = (ABD > 1) ? $clog2(ABD) : 1;
    localparam int CD      = (MAX_COLS * (MAX_COLS + 1)) / 2;
    localparam int CAW     = (CD > 1) ? $clog2(CD) : 1;
    // exact dot sum width, rounded up to whole data-width chunks
    localparam int DOT_MIN = 2 * DATA_WIDTH + $clog2(MAX_INNER) + 1;
    localparam int NCH     = (DOT_MIN + DATA_WIDTH - 1) / DATA_WIDTH;
    localparam int DOTW    = NCH * DATA_WIDTH;
    // alpha * dot plus beta * c, exact with a spare bit
    localparam int ACCW    = DOTW + GAIN_W + 2;

    // configuration registers
    logic [INNER_W-1:0]       r_inner;
    logic [COLS_W-1:0]        r_cols;
    logic signed [GAIN_W-1:0] r_alpha;
    logic signed [GAIN_W-1:0] r_beta;

    // input unpacking
    logic                  w_in_acc;
    logic [OP_W-1:0]       w_op;
    logic [ROW_W-1:0]      w_row;
    logic [COL_W-1:0]      w_col;
    logic [DATA_WIDTH-1:0] w_val;
    logic                  w_ab_ok, w_c_ok;
    logic                  w_a_we, w_b_we, w_c_we, w_start;
    logic [ABAW-1:0]       w_ab_waddr;
    logic [CAW-1:0]        w_c_waddr;

    // sequencer side
    logic                  w_idle, w_ab_rd, w_c_rd;
    logic [ABAW-1:0]       w_a_raddr, w_b_raddr;
    logic [CAW-1:0]        w_c_raddr;
    logic [CW-1:0]         w_seq_row, w_seq_col;
    t_mac_ctl              w_ctl;
    logic [RW-1:0]         w_k_last;
    logic [CW-1:0]         w_n_last;

    // datapath
    logic [DATA_WIDTH-1:0] w_a_rd, w_b_rd, w_c_rd_data;
    logic signed [MUL_W-1:0] w_op_a, w_op_b;
    logic [ACCW-1:0]       w_acc;
    logic [DOTW-1:0]       r_dot;
    logic                  w_ovf;

    // output register
    logic                  r_ov;
    logic [COL_W-1:0]      r_o_row, r_o_col;
    logic [VALUE_W-1:0]    r_o_val;
    logic                  r_o_ovf, r_o_last;
    logic                  w_out_free;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner <= INNER_W'(16);
            r_cols  <= COLS_W'(8);
            r_alpha <= GAIN_W'(1);
            r_beta  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INNER: r_inner <= i_cfg_wdata[INNER_W-1:0];
                CFG_COLS:  r_cols  <= i_cfg_wdata[COLS_W-1:0];
                CFG_ALPHA: r_alpha <= i_cfg_wdata;
                CFG_BETA:  r_beta  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // zero acts as one, oversize acts as the maximum
    always_comb begin
        priority if (r_inner == '0) begin
            w_k_last = '0;
        end else if (int'(r_inner) > MAX_INNER) begin
            w_k_last = RW'(MAX_INNER - 1);
        end else begin
            w_k_last = RW'(int'(r_inner) - 1);
        end
        priority if (r_cols == '0) begin
            w_n_last = '0;
        end else if (int'(r_cols) > MAX_COLS) begin
            w_n_last = CW'(MAX_COLS - 1);
        end else begin
            w_n_last = CW'(int'(r_cols) - 1);
        end
    end

    // ---------------- input side ----------------
    assign s_axis_tready = w_idle;
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_op       = s_axis_tuser;
    assign w_row      = s_axis_tdata[ROW_W-1:0];
    assign w_col      = s_axis_tdata[ROW_W +: COL_W];
    assign w_val      = s_axis_tdata[ROW_W + COL_W +: DATA_WIDTH];

    assign w_ab_ok    = (int'(w_row) < MAX_INNER) && (int'(w_col) < MAX_COLS);
    assign w_c_ok     = (int'(w_col) < MAX_COLS) && (int'(w_row) <= int'(w_col));
    assign w_ab_waddr = ABAW'(int'(w_col) * MAX_INNER + int'(w_row));
    assign w_c_waddr  = CAW'((int'(w_col) * (int'(w_col) + 1)) / 2 + int'(w_row));

    assign w_a_we  = w_in_acc && (w_op == OP_LOAD_A) && w_ab_ok;
    assign w_b_we  = w_in_acc && (w_op == OP_LOAD_B) && w_ab_ok;
    assign w_c_we  = w_in_acc && (w_op == OP_LOAD_C) && w_c_ok;
    assign w_start = w_in_acc && (w_op == OP_START);

    // ---------------- storage ----------------
    puabmac_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (ABD)
    ) u_a_mem (
        .i_clk   (i_clk),
        .i_we    (w_a_we),
        .i_waddr (w_ab_waddr),
        .i_wdata (w_val),
        .i_re    (w_ab_rd),
        .i_raddr (w_a_raddr),
        .o_rdata (w_a_rd)
    );

    puabmac_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (ABD)
    ) u_b_mem (
        .i_clk   (i_clk),
        .i_we    (w_b_we),
        .i_waddr (w_ab_waddr),
        .i_wdata (w_val),
        .i_re    (w_ab_rd),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rd)
    );

    // old c entry is read once per entry and held for the beta step
    puabmac_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CD)
    ) u_c_mem (
        .i_clk   (i_clk),
        .i_we    (w_c_we),
        .i_waddr (w_c_waddr),
        .i_wdata (w_val),
        .i_re    (w_c_rd),
        .i_raddr (w_c_raddr),
        .o_rdata (w_c_rd_data)
    );

    // ---------------- sequencer ----------------
    puabmac_seq #(
        .MAX_INNER (MAX_INNER),
        .MAX_COLS  (MAX_COLS),
        .NCHUNK    (NCH)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_k_last   (w_k_last),
        .i_n_last   (w_n_last),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_ab_rd    (w_ab_rd),
        .o_c_rd     (w_c_rd),
        .o_a_raddr  (w_a_raddr),
        .o_b_raddr  (w_b_raddr),
        .o_c_raddr  (w_c_raddr),
        .o_row      (w_seq_row),
        .o_col      (w_seq_col),
        .o_ctl      (w_ctl)
    );

    // ---------------- shared multiplier operands ----------------
    // dot sum is split into unsigned low chunks and a signed top chunk
    always_comb begin
        unique case (w_ctl.src)
            SRC_AB: begin
                w_op_a = MUL_W'(signed'(w_a_rd));
                w_op_b = MUL_W'(signed'(w_b_rd));
            end
            SRC_LOW: begin
                w_op_a = MUL_W'(r_alpha);
                w_op_b = MUL_W'(r_dot[int'(w_ctl.step) * DATA_WIDTH +: DATA_WIDTH]);
            end
            SRC_TOP: begin
                w_op_a = MUL_W'(r_alpha);
                w_op_b = MUL_W'(signed'(r_dot[DOTW-1 -: DATA_WIDTH]));
            end
            SRC_BETA: begin
                w_op_a = MUL_W'(r_beta);
                w_op_b = MUL_W'(signed'(w_c_rd_data));
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    puabmac_mul_acc #(
        .MW         (MUL_W),
        .ACCW       (ACCW),
        .SHIFT_UNIT (DATA_WIDTH)
    ) u_mul_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_ctl.mul_vld),
        .i_shift (w_ctl.step),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .i_clr   (w_ctl.clr),
        .o_acc   (w_acc)
    );

    // finished dot sum parked while the accumulator builds the result
    always_ff @(posedge i_clk) begin
        if (w_ctl.cap) begin
            r_dot <= w_acc[DOTW-1:0];
        end
    end

    // fits when every bit from the sign bit of the data width up agrees
    assign w_ovf = !((&w_acc[ACCW-1:DATA_WIDTH-1]) || !(|w_acc[ACCW-1:DATA_WIDTH-1]));

    // ---------------- output register ----------------
    assign w_out_free = !r_ov || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_ctl.emit) begin
            r_ov <= 1'b1;
        end else if (m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.emit) begin
            r_o_row  <= COL_W'(w_seq_row);
            r_o_col  <= COL_W'(w_seq_col);
            r_o_val  <= VALUE_W'(signed'(w_acc[DATA_WIDTH-1:0]));
            r_o_ovf  <= w_ovf;
            r_o_last <= w_ctl.last;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {2'b00, r_o_val, r_o_col, r_o_row};
    assign m_axis_tuser  = r_o_ovf;
    assign m_axis_tlast  = r_o_last;

endmodule

`default_nettype wire

// ----- hdl/puabmac_ram.sv -----
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`default_nettype none

module puabmac_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hdl/puabmac_mul_acc.sv -----
// shared signed multiplier with product register and shifted wide accumulator
// depends on puabmac_pkg
`default_nettype none

module puabmac_mul_acc #(
    parameter int MW         = 33,
    parameter int ACCW       = 132,
    parameter int SHIFT_UNIT = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_vld,
    input  wire logic [puabmac_pkg::STEP_W-1:0] i_shift,
    input  wire logic signed [MW-1:0]           i_op_a,
    input  wire logic signed [MW-1:0]           i_op_b,
    input  wire logic                           i_clr,
    output logic [ACCW-1:0]                     o_acc
);

    import puabmac_pkg::*;

    logic signed [2*MW-1:0] r_prod;
    logic                   r_pvld;
    logic [STEP_W-1:0]      r_psh;
    logic [ACCW-1:0]        r_acc;
    logic signed [ACCW-1:0] w_ext;
    logic [ACCW-1:0]        w_term;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
        r_psh  <= i_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
        end else begin
            r_pvld <= i_vld;
        end
    end

    // product weighted by its chunk position
    assign w_ext  = ACCW'(r_prod);
    assign w_term = w_ext << (int'(r_psh) * SHIFT_UNIT);

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_acc <= '0;
        end else if (r_pvld) begin
            r_acc <= r_acc + w_term;
        end
    end

    assign o_acc = r_acc;

endmodule

`default_nettype wire

// ----- hdl/puabmac_seq.sv -----
// sequencer: walks the upper triangle, the dot rows and the scale steps
// depends on puabmac_pkg
`default_nettype none

module puabmac_seq #(
    parameter int MAX_INNER = 16,
    parameter int MAX_COLS  = 8,
    parameter int NCHUNK    = 3,
    localparam int RW   = (MAX_INNER > 1) ? $clog2(MAX_INNER) : 1,
    localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1,
    localparam int ABD  = MAX_INNER * MAX_COLS,
    localparam int ABAW = (ABD > 1) ? $clog2(ABD) : 1,
    localparam int CD   = (MAX_COLS * (MAX_COLS + 1)) / 2,
    localparam int CAW  = (CD > 1) ? $clog2(CD) : 1
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [RW-1:0]   i_k_last,
    input  wire logic [CW-1:0]   i_n_last,
    input  wire logic            i_out_free,
    output logic                 o_idle,
    output logic                 o_ab_rd,
    output logic                 o_c_rd,
    output logic [ABAW-1:0]      o_a_raddr,
    output logic [ABAW-1:0]      o_b_raddr,
    output logic [CAW-1:0]       o_c_raddr,
    output logic [CW-1:0]        o_row,
    output logic [CW-1:0]        o_col,
    output puabmac_pkg::t_mac_ctl o_ctl
);

    import puabmac_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_DOT   = 7'b0000010,
        ST_DWAIT = 7'b0000100,
        ST_CAPT  = 7'b0001000,
        ST_SCALE = 7'b0010000,
        ST_SWAIT = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_j, n_j;
    logic [RW-1:0]     r_r, n_r;
    logic [STEP_W-1:0] r_s, n_s;
    logic              r_w, n_w;
    logic              r_mvld, n_mvld;
    t_src              r_src, n_src;
    logic [STEP_W-1:0] r_step, n_step;
    logic              w_clr, w_cap, w_emit;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_r     = r_r;
        n_s     = r_s;
        n_w     = r_w;
        n_mvld  = 1'b0;
        n_src   = SRC_AB;
        n_step  = '0;
        w_clr   = 1'b0;
        w_cap   = 1'b0;
        w_emit  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    w_clr   = 1'b1;
                    n_i     = '0;
                    n_j     = '0;
                    n_r     = '0;
                    n_state = ST_DOT;
                end
            end
            ST_DOT: begin
                n_mvld = 1'b1;
                if (r_r == i_k_last) begin
                    n_r     = '0;
                    n_w     = 1'b0;
                    n_state = ST_DWAIT;
                end else begin
                    n_r = r_r + 1'b1;
                end
            end
            ST_DWAIT: begin
                if (r_w) begin
                    n_w     = 1'b0;
                    n_state = ST_CAPT;
                end else begin
                    n_w = 1'b1;
                end
            end
            ST_CAPT: begin
                // dot product is complete: park it and reuse the accumulator
                w_cap   = 1'b1;
                w_clr   = 1'b1;
                n_s     = '0;
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                n_mvld = 1'b1;
                priority if (r_s < STEP_W'(NCHUNK - 1)) begin
                    n_src  = SRC_LOW;
                    n_step = r_s;
                end else if (r_s == STEP_W'(NCHUNK - 1)) begin
                    n_src  = SRC_TOP;
                    n_step = r_s;
                end else begin
                    n_src  = SRC_BETA;
                    n_step = '0;
                end
                if (r_s == STEP_W'(NCHUNK)) begin
                    n_w     = 1'b0;
                    n_state = ST_SWAIT;
                end else begin
                    n_s = r_s + 1'b1;
                end
            end
            ST_SWAIT: begin
                if (r_w) begin
                    n_w     = 1'b0;
                    n_state = ST_EMIT;
                end else begin
                    n_w = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_out_free) begin
                    w_emit = 1'b1;
                    w_clr  = 1'b1;
                    n_r    = '0;
                    if (r_i == r_j) begin
                        if (r_j == i_n_last) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_j     = r_j + 1'b1;
                            n_i     = '0;
                            n_state = ST_DOT;
                        end
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = ST_DOT;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_r     <= '0;
            r_s     <= '0;
            r_w     <= 1'b0;
            r_mvld  <= 1'b0;
            r_src   <= SRC_AB;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_r     <= n_r;
            r_s     <= n_s;
            r_w     <= n_w;
            r_mvld  <= n_mvld;
            r_src   <= n_src;
            r_step  <= n_step;
        end
    end

    assign o_idle    = (r_state == ST_IDLE);
    assign o_ab_rd   = (r_state == ST_DOT);
    assign o_c_rd    = (r_state == ST_DOT) && (r_r == '0);
    assign o_a_raddr = ABAW'(int'(r_i) * MAX_INNER + int'(r_r));
    assign o_b_raddr = ABAW'(int'(r_j) * MAX_INNER + int'(r_r));
    assign o_c_raddr = CAW'((int'(r_j) * (int'(r_j) + 1)) / 2 + int'(r_i));
    assign o_row     = r_i;
    assign o_col     = r_j;

    assign o_ctl.mul_vld = r_mvld;
    assign o_ctl.src     = r_src;
    assign o_ctl.step    = r_step;
    assign o_ctl.clr     = w_clr;
    assign o_ctl.cap     = w_cap;
    assign o_ctl.emit    = w_emit;
    assign o_ctl.last    = (r_i == r_j) && (r_j == i_n_last);

endmodule

`default_nettype wire

// ----- hdl/puabmac_checker.sv -----
// port-level checker for the packed upper-triangle mac block, bound to the top
// depends on puabmac_pkg and packed_upper_at_b_multiply_accumulate_unit
`default_nettype none

module puabmac_checker (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                i_cfg_we,
    input wire logic [puabmac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input wire logic [puabmac_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input wire logic                                s_axis_tvalid,
    input wire logic                                s_axis_tready,
    input wire logic [puabmac_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    input wire logic [puabmac_pkg::OP_W-1:0]        s_axis_tuser,
    input wire logic                                m_axis_tvalid,
    input wire logic                                m_axis_tready,
    input wire logic [puabmac_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    input wire logic                                m_axis_tuser,
    input wire logic                                m_axis_tlast
);

    import puabmac_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // reset empties the output register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a start transaction puts the block into its busy run
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_START) |=> !s_axis_tready)
        else $error("input ready right after start");

    // the run keeps going until its last entry has been produced
    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready before the last entry");

endmodule

bind packed_upper_at_b_multiply_accumulate_unit puabmac_checker u_puabmac_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// self-checking bench of packed_upper_at_b_multiply_accumulate_unit: loads a, b and
// old c, starts runs under many gain and size settings, checks each c entry in order
// depends on puabmac_pkg and the rtl of the block

module tb;
    import puabmac_pkg::*;

    localparam int MAX_INNER     = DEF_MAX_INNER;
    localparam int MAX_COLS      = DEF_MAX_COLS;
    localparam int AB_DEPTH      = MAX_INNER * MAX_COLS;
    localparam int C_DEPTH       = MAX_COLS * (MAX_COLS + 1) / 2;
    // longest entry plus pipe drain, covers loads still in flight
    localparam int SETTLE_CYCLES = 48;
    // long receiver hold-off so that the output register and the input back up
    localparam int HOLD_CYCLES   = 400;
    localparam int MAX_REPORTS   = 10;
    localparam int RAND_ITEMS    = 100;
    localparam int RAND_ENTRIES  = 48;

    // one input transaction: op travels in tuser, the rest in tdata
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [VALUE_W-1:0] value;
    } mac_item_t;

    // one c entry as it leaves the block
    typedef struct packed {
        logic [2:0]  row;
        logic [2:0]  col;
        logic [31:0] value;
        logic        ovf;
        logic        last;
    } c_entry_t;

    // directed row: where typed is set the run has one entry and its value is given
    typedef struct packed {
        mac_item_t   item;
        logic        typed;
        logic [31:0] exp_value;
        logic        exp_ovf;
    } directed_row_t;

    // ------------------------------------------------------------------
    // clock, reset and block ports
    // ------------------------------------------------------------------
    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = CFG_INNER;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    wire                   s_axis_tready;
    // [3:0] row, [6:4] col, [38:7] value, [39] zero
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // [1:0] op
    logic [OP_W-1:0]       s_axis_tuser = OP_LOAD_A;
    wire                   m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // [2:0] out_row, [5:3] out_col, [37:6] out_value, [39:38] zero
    wire [OUT_DATA_W-1:0]  m_axis_tdata;
    // [0] overflow
    wire                   m_axis_tuser;
    wire                   m_axis_tlast;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    packed_upper_at_b_multiply_accumulate_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // shadow of the block: memories, written marks, registers after reset
    // ------------------------------------------------------------------
    logic signed [31:0] a_mem [AB_DEPTH];
    logic signed [31:0] b_mem [AB_DEPTH];
    logic signed [31:0] c_mem [C_DEPTH];
    bit                 a_set [AB_DEPTH];
    bit                 b_set [AB_DEPTH];
    bit                 c_set [C_DEPTH];
    logic [INNER_W-1:0] inner_reg = 5'd16;
    logic [COLS_W-1:0]  cols_reg  = 4'd8;
    logic signed [31:0] alpha_reg = 32'sd1;
    logic signed [31:0] beta_reg  = 32'sd0;

    c_entry_t c_expected [$];   // c entries still owed by the block, oldest first
    int       c_entries_due = 0;
    int       mismatches = 0;
    bit       hold_armed = 1'b0;

    // sizes as the block uses them: zero reads as one, oversize is clipped
    function automatic int eff_inner();
        if (inner_reg == 0) return 1;
        if (int'(inner_reg) > MAX_INNER) return MAX_INNER;
        return int'(inner_reg);
    endfunction

    function automatic int eff_cols();
        if (cols_reg == 0) return 1;
        if (int'(cols_reg) > MAX_COLS) return MAX_COLS;
        return int'(cols_reg);
    endfunction

    function automatic int c_addr(input int r, input int c);
        return c * (c + 1) / 2 + r;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int idle_cycles();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) return 0;
        if (pick < 19) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // operand values biased to the extremes so that wrapping shows up often
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return 32'($urandom_range(0, 32)) - 32'd16;
            default: return $urandom;
        endcase
    endfunction

    // update the shadow with one accepted transaction; a start queues its c entries
    task automatic apply_item(input mac_item_t it, input logic typed,
                              input logic [31:0] typed_value, input logic typed_ovf);
        int k, n, i, j, r, addr;
        logic signed [127:0] dot, res, wa, wb;
        c_entry_t e;
        case (it.op)
            OP_LOAD_A, OP_LOAD_B: begin
                addr = int'(it.col) * MAX_INNER + int'(it.row);
                if (it.op == OP_LOAD_A) begin
                    a_mem[addr] = it.value;
                    a_set[addr] = 1'b1;
                end else begin
                    b_mem[addr] = it.value;
                    b_set[addr] = 1'b1;
                end
            end
            OP_LOAD_C: begin
                // below-diagonal loads are dropped
                if (it.row <= it.col) begin
                    addr = c_addr(int'(it.row), int'(it.col));
                    c_mem[addr] = it.value;
                    c_set[addr] = 1'b1;
                end
            end
            OP_START: begin
                k = eff_inner();
                n = eff_cols();
                for (j = 0; j < n; j++) begin
                    for (i = 0; i <= j; i++) begin
                        // exact sum first, wrap only at the very end
                        dot = '0;
                        for (r = 0; r < k; r++) begin
                            wa = a_mem[i * MAX_INNER + r];
                            wb = b_mem[j * MAX_INNER + r];
                            dot = dot + wa * wb;
                        end
                        wa = alpha_reg;
                        res = wa * dot;
                        wa = beta_reg;
                        wb = c_mem[c_addr(i, j)];
                        res = res + wa * wb;
                        e.row = 3'(i);
                        e.col = 3'(j);
                        e.value = res[31:0];
                        wa = $signed(res[31:0]);
                        e.ovf = (wa != res);
                        e.last = (j == n - 1) && (i == j);
                        if (typed) begin
                            e.value = typed_value;
                            e.ovf = typed_ovf;
                        end
                        c_expected.push_back(e);
                        c_entries_due++;
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // driving: inputs change at the falling edge, handshakes seen at the rising edge
    // ------------------------------------------------------------------
    task automatic send_item(input mac_item_t it, input logic typed,
                             input logic [31:0] typed_value, input logic typed_ovf,
                             input bit no_gaps);
        int gap;
        gap = no_gaps ? 0 : idle_cycles();
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tdata = {1'b0, it.value, it.col, it.row};
        s_axis_tuser = it.op;
        do @(posedge i_clk); while (!s_axis_tready);
        apply_item(it, typed, typed_value, typed_ovf);
    endtask

    // no results owed, then room for loads and the pipe to finish
    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (c_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_INNER: inner_reg = data[INNER_W-1:0];
            CFG_COLS:  cols_reg = data[COLS_W-1:0];
            CFG_ALPHA: alpha_reg = data;
            CFG_BETA:  beta_reg = data;
            default: ;
        endcase
    endtask

    task automatic program_regs(input logic [31:0] inner, input logic [31:0] cols,
                                input logic [31:0] alpha, input logic [31:0] beta);
        wait_idle();
        write_reg(CFG_INNER, inner);
        write_reg(CFG_COLS, cols);
        write_reg(CFG_ALPHA, alpha);
        write_reg(CFG_BETA, beta);
    endtask

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------
    task automatic note_error(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("mismatch at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) note_error($sformatf("%s expected %h got %h", name, want, got));
    endtask

    task automatic check_entry(input c_entry_t got);
        c_entry_t want;
        if (c_expected.size() == 0) begin
            note_error($sformatf("c entry row %0d col %0d value %h with none expected",
                                 got.row, got.col, got.value));
            return;
        end
        want = c_expected.pop_front();
        check_field("out_row", 32'(want.row), 32'(got.row));
        check_field("out_col", 32'(want.col), 32'(got.col));
        check_field("out_value", want.value, got.value);
        check_field("overflow", 32'(want.ovf), 32'(got.ovf));
        check_field("last", 32'(want.last), 32'(got.last));
    endtask

    // result side: random stalls, calm stretches, and one long hold-off on request
    initial begin : result_sink
        c_entry_t got;
        int gap;
        int calm;
        calm = 0;
        @(posedge i_rst_n);
        forever begin
            if (hold_armed) begin
                // let a result sit in the output register, then refuse it for a while
                @(negedge i_clk);
                m_axis_tready = 1'b0;
                do @(posedge i_clk); while (!m_axis_tvalid);
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_armed = 1'b0;
            end else if (calm > 0) begin
                calm--;
            end else begin
                if ($urandom_range(0, 15) == 0) calm = $urandom_range(8, 40);
                gap = idle_cycles();
                if (gap > 0) begin
                    @(negedge i_clk);
                    m_axis_tready = 1'b0;
                    repeat (gap - 1) @(negedge i_clk);
                end
            end
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            got.row = m_axis_tdata[2:0];
            got.col = m_axis_tdata[5:3];
            got.value = m_axis_tdata[37:6];
            got.ovf = m_axis_tuser;
            got.last = m_axis_tlast;
            check_entry(got);
        end
    end

    // ------------------------------------------------------------------
    // directed part, k = n = 1 so that every start gives a single entry:
    // product extremes, wrap and no wrap, start fields ignored,
    // below-diagonal c loads dropped, old c ignored while beta is zero
    // ------------------------------------------------------------------
    directed_row_t directed_tab [19] = '{
        '{'{OP_LOAD_A, 4'd0,  3'd0, 32'h8000_0000}, 1'b0, 32'h0, 1'b0},
        '{'{OP_LOAD_B, 4'd0,  3'd0, 32'h8000_0000}, 1'b0, 32'h0, 1'b0},
        '{'{OP_LOAD_C, 4'd0,  3'd0, 32'h7fff_ffff}, 1'b0, 32'h0, 1'b0},
        // min times min: 2^62 wraps to zero
        '{'{OP_START,  4'd15, 3'd7, 32'hffff_ffff}, 1'b1, 32'h0000_0000, 1'b1},
        '{'{OP_LOAD_A, 4'd0,  3'd0, 32'h7fff_ffff}, 1'b0, 32'h0, 1'b0},
        '{'{OP_LOAD_B, 4'd0,  3'd0, 32'h7fff_ffff}, 1'b0, 32'h0, 1'b0},
        // max times max wraps to one
        '{'{OP_START,  4'd0,  3'd0, 32'h0000_0000}, 1'b1, 32'h0000_0001, 1'b1},
        '{'{OP_LOAD_B, 4'd0,  3'd0, 32'hffff_ffff}, 1'b0, 32'h0, 1'b0},
        // max times minus one still fits
        '{'{OP_START,  4'd9,  3'd2, 32'h5a5a_5a5a}, 1'b1, 32'h8000_0001, 1'b0},
        '{'{OP_LOAD_A, 4'd15, 3'd7, 32'h1234_5678}, 1'b0, 32'h0, 1'b0},
        '{'{OP_LOAD_B, 4'd15, 3'd7, 32'hedcb_a987}, 1'b0, 32'h0, 1'b0},
        // below the diagonal: dropped; row 7 col 7 lies on it and is kept
        '{'{OP_LOAD_C, 4'd7,  3'd3, 32'h5555_5555}, 1'b0, 32'h0, 1'b0},
        '{'{OP_LOAD_C, 4'd15, 3'd0, 32'h0f0f_0f0f}, 1'b0, 32'h0, 1'b0},
        '{'{OP_LOAD_C, 4'd7,  3'd7, 32'haaaa_aaaa}, 1'b0, 32'h0, 1'b0},
        '{'{OP_LOAD_A, 4'd0,  3'd0, 32'd3},         1'b0, 32'h0, 1'b0},
        '{'{OP_LOAD_B, 4'd0,  3'd0, 32'd5},         1'b0, 32'h0, 1'b0},
        '{'{OP_START,  4'd0,  3'd0, 32'h0000_0000}, 1'b1, 32'd15, 1'b0},
        // old c changes but beta is zero
        '{'{OP_LOAD_C, 4'd0,  3'd0, 32'hffff_ffff}, 1'b0, 32'h0, 1'b0},
        '{'{OP_START,  4'd8,  3'd5, 32'hc3c3_c3c3}, 1'b1, 32'd15, 1'b0}
    };

    // opening random phases: size clamps and gain extremes, two runs over all columns
    logic [31:0] preset_inner [5] = '{32'hffff_ffe0, 32'd2, 32'd31, 32'd3, 32'd3};
    logic [31:0] preset_cols  [5] = '{32'd0, 32'd8, 32'd8, 32'd2, 32'hffff_fff5};
    logic [31:0] preset_alpha [5] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0,
                                      32'h0, 32'hffff_ffff};
    logic [31:0] preset_beta  [5] = '{32'h7fff_ffff, 32'h8000_0000, 32'h0,
                                      32'h1, 32'hffff_ffff};
    // the phase after the all-column run keeps its settings so loads pile up behind it
    bit          preset_cfg   [5] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

    initial begin : stimulus
        mac_item_t batch [$];
        mac_item_t it, tmp;
        int phase, rand_items, entries_base, k, n, r, c, extra, x, y;
        bit quiet, do_cfg, do_start;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        program_regs(32'd1, 32'd1, 32'd1, 32'd0);
        foreach (directed_tab[d])
            send_item(directed_tab[d].item, directed_tab[d].typed,
                      directed_tab[d].exp_value, directed_tab[d].exp_ovf, 1'b0);

        // random phases: settings, the loads a run needs plus rewrites and noise, start
        phase = 0;
        rand_items = 0;
        entries_base = c_entries_due;
        while (phase < 5 || rand_items < RAND_ITEMS ||
               c_entries_due - entries_base < RAND_ENTRIES) begin
            if (phase < 5) begin
                do_cfg = preset_cfg[phase];
                if (do_cfg)
                    program_regs(preset_inner[phase], preset_cols[phase],
                                 preset_alpha[phase], preset_beta[phase]);
            end else if ($urandom_range(0, 3) != 0) begin
                case ($urandom_range(0, 9))
                    0: k = $urandom_range(0, 31);
                    1: k = $urandom_range(5, 16);
                    default: k = $urandom_range(1, 4);
                endcase
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
                program_regs({27'($urandom), 5'(k)}, {28'($urandom), 4'(n)},
                             pick_value(), pick_value());
            end
            k = eff_inner();
            n = eff_cols();

            // a start must never read an element that was never loaded
            batch.delete();
            for (c = 0; c < n; c++) begin
                for (r = 0; r < k; r++) begin
                    it.row = ROW_W'(r);
                    it.col = COL_W'(c);
                    if (!a_set[c * MAX_INNER + r]) begin
                        it.op = OP_LOAD_A;
                        it.value = pick_value();
                        batch.push_back(it);
                    end
                    if (!b_set[c * MAX_INNER + r]) begin
                        it.op = OP_LOAD_B;
                        it.value = pick_value();
                        batch.push_back(it);
                    end
                end
                for (r = 0; r <= c; r++) begin
                    if (!c_set[c_addr(r, c)]) begin
                        it.op = OP_LOAD_C;
                        it.row = ROW_W'(r);
                        it.col = COL_W'(c);
                        it.value = pick_value();
                        batch.push_back(it);
                    end
                end
            end
            extra = $urandom_range(0, 8);
            repeat (extra) begin
                it.op = OP_W'($urandom_range(OP_LOAD_A, OP_LOAD_C));
                it.value = pick_value();
                if ($urandom_range(0, 3) == 0) begin
                    // anywhere, below-diagonal c included
                    it.row = ROW_W'($urandom);
                    it.col = COL_W'($urandom);
                end else begin
                    c = $urandom_range(0, n - 1);
                    it.col = COL_W'(c);
                    it.row = (it.op == OP_LOAD_C) ? ROW_W'($urandom_range(0, c))
                                                  : ROW_W'($urandom_range(0, k - 1));
                end
                batch.push_back(it);
            end
            for (x = batch.size() - 1; x > 0; x--) begin
                y = $urandom_range(0, x);
                tmp = batch[x];
                batch[x] = batch[y];
                batch[y] = tmp;
            end

            quiet = ($urandom_range(0, 3) == 0);
            foreach (batch[b]) begin
                send_item(batch[b], 1'b0, 32'h0, 1'b0, quiet);
                if (!(batch[b].op == OP_LOAD_C && batch[b].row > batch[b].col))
                    rand_items++;
            end

            // now and then a sequence ends without its start
            do_start = (phase < 5) || ($urandom_range(0, 7) != 0);
            if (do_start) begin
                if (phase == 1) hold_armed = 1'b1;
                it.op = OP_START;
                it.row = ROW_W'($urandom);
                it.col = COL_W'($urandom);
                it.value = $urandom;
                send_item(it, 1'b0, 32'h0, 1'b0, quiet);
                rand_items++;
            end
            phase++;
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (c_expected.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && c_expected.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin : watchdog
        #50_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/puabmac_pkg.sv
hdl/puabmac_ram.sv
hdl/puabmac_mul_acc.sv
hdl/puabmac_seq.sv
hdl/packed_upper_at_b_multiply_accumulate_unit.sv
hdl/puabmac_checker.sv
tb/tb.sv
